[rtl/nals_pkg.sv]
package nals_pkg;

   // result kinds
   localparam logic [1:0] OUT_BYTE      = 2'd0;
   localparam logic [1:0] OUT_FIELD_END = 2'd1;
   localparam logic [1:0] OUT_LIST_END  = 2'd2;
   localparam logic [1:0] OUT_ERROR     = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_ESCAPE   = 2'd1;
   localparam logic [1:0] ERR_CLOSE    = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   // bracket kinds kept on the nesting stack
   localparam logic [1:0] BK_SQUARE = 2'd0;
   localparam logic [1:0] BK_PAREN  = 2'd1;
   localparam logic [1:0] BK_CURLY  = 2'd2;

   // input kinds
   localparam logic IN_CHAR = 1'b0;
   localparam logic IN_EOT  = 1'b1;

   // character constants
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LSQ    = 8'h5b;
   localparam logic [7:0] CH_RSQ    = 8'h5d;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_LCUR   = 8'h7b;
   localparam logic [7:0] CH_RCUR   = 8'h7d;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;

   localparam logic [7:0]  SEP_RESET = 8'd44;
   localparam logic [15:0] COUNT_MAX = 16'hffff;

   // classified character as it travels from front to back
   typedef struct packed {
      logic       eot;
      logic [7:0] data;
      logic       is_sep;
      logic       is_bslash;
      logic       is_quote;
      logic       is_open;
      logic       is_close;
      logic [1:0] bk;
      logic       is_ws;
      logic       esc_ok;
      logic [7:0] esc_byte;
   } item_type;

endpackage

[rtl/nals_front.sv]
module nals_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data,
   input  logic               in_kind,
   input  logic [7:0]         in_byte,
   output nals_pkg::item_type item
);

   logic [7:0] separator_ff;
   logic [7:0] separator_in;

   // separator register
   assign csr_ready    = 1'b1;
   assign separator_in = (csr_valid && csr_ready) ? csr_data : separator_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= nals_pkg::SEP_RESET;
      end else begin
         separator_ff <= separator_in;
      end
   end

   // character classification
   always_comb begin
      item.eot       = (in_kind == nals_pkg::IN_EOT);
      item.data      = in_byte;
      item.is_sep    = (in_byte == separator_ff);
      item.is_bslash = (in_byte == nals_pkg::CH_BSLASH);
      item.is_quote  = (in_byte == nals_pkg::CH_QUOTE);
      item.is_open   = (in_byte == nals_pkg::CH_LSQ) || (in_byte == nals_pkg::CH_LPAR) ||
                       (in_byte == nals_pkg::CH_LCUR);
      item.is_close  = (in_byte == nals_pkg::CH_RSQ) || (in_byte == nals_pkg::CH_RPAR) ||
                       (in_byte == nals_pkg::CH_RCUR);
      if (in_byte == nals_pkg::CH_LSQ || in_byte == nals_pkg::CH_RSQ) begin
         item.bk = nals_pkg::BK_SQUARE;
      end else if (in_byte == nals_pkg::CH_LPAR || in_byte == nals_pkg::CH_RPAR) begin
         item.bk = nals_pkg::BK_PAREN;
      end else begin
         item.bk = nals_pkg::BK_CURLY;
      end
      item.is_ws     = (in_byte == nals_pkg::CH_SPACE) || (in_byte == nals_pkg::CH_TAB) ||
                       (in_byte == nals_pkg::CH_LF);
      // escape decode
      item.esc_ok    = 1'b1;
      case (in_byte)
         nals_pkg::CH_N:      item.esc_byte = nals_pkg::CH_LF;
         nals_pkg::CH_T:      item.esc_byte = nals_pkg::CH_TAB;
         nals_pkg::CH_BSLASH: item.esc_byte = nals_pkg::CH_BSLASH;
         nals_pkg::CH_QUOTE:  item.esc_byte = nals_pkg::CH_QUOTE;
         default: begin
            item.esc_ok   = 1'b0;
            item.esc_byte = 8'd0;
         end
      endcase
   end

endmodule

[rtl/nals_queue.sv]
module nals_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  nals_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output nals_pkg::item_type head
);

   nals_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/nals_back.sv]
module nals_back #(
   parameter int NEST_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  nals_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_byte,
   output logic [1:0]         rsp_err,
   output logic [15:0]        rsp_count
);

   localparam int DW = $clog2(NEST_DEPTH + 1);

   logic [2*NEST_DEPTH-1:0] stack_ff, stack_in;
   logic [DW-1:0]           depth_ff, depth_in;
   logic                    verb_ff, verb_in;
   logic                    esc_ff, esc_in;
   logic                    abort_ff, abort_in;
   logic [15:0]             fields_ff, fields_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic [1:0]  out_err_ff, out_err_in;
   logic [15:0] out_count_ff, out_count_in;

   logic                    res;
   logic [2*NEST_DEPTH+1:0] stack_push, stack_pop;
   logic                    at_zero, at_full;

   assign q_pop   = q_valid && (!out_valid_ff || rsp_ready);
   assign at_zero = (depth_ff == '0);
   assign at_full = (depth_ff == DW'(NEST_DEPTH));

   // shift stack: the top always sits in the lowest two bits
   assign stack_push = {stack_ff, q_item.bk};
   assign stack_pop  = {2'b00, stack_ff};

   // parser step
   always_comb begin
      stack_in     = stack_ff;
      depth_in     = depth_ff;
      verb_in      = verb_ff;
      esc_in       = esc_ff;
      abort_in     = abort_ff;
      fields_in    = fields_ff;
      res          = 1'b0;
      out_kind_in  = nals_pkg::OUT_BYTE;
      out_byte_in  = 8'd0;
      out_err_in   = nals_pkg::ERR_NONE;
      out_count_in = 16'd0;
      if (q_pop) begin
         if (q_item.eot) begin
            res         = 1'b1;
            out_kind_in = nals_pkg::OUT_LIST_END;
            if (!abort_ff) begin
               out_count_in = (fields_ff == nals_pkg::COUNT_MAX) ? nals_pkg::COUNT_MAX
                                                                 : fields_ff + 16'd1;
               if (esc_ff) begin
                  out_err_in = nals_pkg::ERR_ESCAPE;
               end
            end
            depth_in  = '0;
            verb_in   = 1'b0;
            esc_in    = 1'b0;
            abort_in  = 1'b0;
            fields_in = 16'd0;
         end else if (abort_ff) begin
            res = 1'b0;
         end else if (esc_ff) begin
            esc_in = 1'b0;
            res    = 1'b1;
            if (q_item.esc_ok) begin
               out_byte_in = q_item.esc_byte;
            end else begin
               out_kind_in = nals_pkg::OUT_ERROR;
               out_err_in  = nals_pkg::ERR_ESCAPE;
            end
         end else if (q_item.is_sep && at_zero) begin
            res         = 1'b1;
            out_kind_in = nals_pkg::OUT_FIELD_END;
            if (fields_ff != nals_pkg::COUNT_MAX) begin
               fields_in = fields_ff + 16'd1;
            end
         end else if (q_item.is_bslash) begin
            esc_in = 1'b1;
         end else if (q_item.is_quote) begin
            verb_in = ~verb_ff;
         end else if (q_item.is_open) begin
            res = 1'b1;
            if (at_full) begin
               abort_in    = 1'b1;
               out_kind_in = nals_pkg::OUT_ERROR;
               out_err_in  = nals_pkg::ERR_OVERFLOW;
            end else begin
               stack_in    = stack_push[2*NEST_DEPTH-1:0];
               depth_in    = depth_ff + DW'(1);
               out_byte_in = q_item.data;
            end
         end else if (q_item.is_close) begin
            res = 1'b1;
            if (at_zero || stack_ff[1:0] != q_item.bk) begin
               abort_in    = 1'b1;
               out_kind_in = nals_pkg::OUT_ERROR;
               out_err_in  = nals_pkg::ERR_CLOSE;
            end else begin
               stack_in    = stack_pop[2*NEST_DEPTH+1:2];
               depth_in    = depth_ff - DW'(1);
               out_byte_in = q_item.data;
            end
         end else if (verb_ff || !q_item.is_ws) begin
            res         = 1'b1;
            out_byte_in = q_item.data;
         end
      end
   end

   // output register valid
   always_comb begin
      if (q_pop) begin
         out_valid_in = res;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         verb_ff      <= 1'b0;
         esc_ff       <= 1'b0;
         abort_ff     <= 1'b0;
         fields_ff    <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         verb_ff      <= verb_in;
         esc_ff       <= esc_in;
         abort_ff     <= abort_in;
         fields_ff    <= fields_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // stack contents and result payload
   always_ff @(posedge clock) begin
      stack_ff <= stack_in;
      if (q_pop && res) begin
         out_kind_ff  <= out_kind_in;
         out_byte_ff  <= out_byte_in;
         out_err_ff   <= out_err_in;
         out_count_ff <= out_count_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_byte  = out_byte_ff;
   assign rsp_err   = out_err_ff;
   assign rsp_count = out_count_ff;

endmodule

[rtl/nest_aware_list_splitter.sv]
// Splits a text, one character per transaction, into fields at the separator
// byte while no bracket is open, with quote, escape and whitespace handling.
// The block takes one character per clock cycle while the rsp side is not
// stalled. A character is classified on acceptance and lands in a two-entry
// queue; the back end pops it from the queue head and its result is
// registered before it is shown on the rsp side. The back end's stack update
// for each character sets the rate. The nesting stack is a shift register,
// so there is no clearing pass after reset. Characters that cause no result
// (dropped whitespace, quotes, backslashes, anything after an abort) just
// leave the queue. The separator is written over the csr channel and must
// only be changed while the block is idle.
module nest_aware_list_splitter #(
   parameter int NEST_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_byte, error_code, field_count, zero pad
   output logic [1:0]  rsp_tuser,   // out_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // separator
);

   nals_pkg::item_type front_item;
   nals_pkg::item_type q_head;
   logic               q_full;
   logic               q_valid;
   logic               q_pop;
   logic [1:0]         rsp_kind;
   logic [7:0]         rsp_byte;
   logic [1:0]         rsp_err;
   logic [15:0]        rsp_count;

   assign req_tready = !q_full;

   // classification
   nals_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .in_kind   (req_tuser),
      .in_byte   (req_tdata),
      .item      (front_item)
   );

   // decoupling queue
   nals_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && req_tready),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   // parser state and result register
   nals_back #(
      .NEST_DEPTH (NEST_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_kind),
      .rsp_byte  (rsp_byte),
      .rsp_err   (rsp_err),
      .rsp_count (rsp_count)
   );

   assign rsp_tuser = rsp_kind;
   assign rsp_tdata = {6'd0, rsp_count, rsp_err, rsp_byte};

endmodule

[rtl/nals_checker.sv]
module nals_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // byte field is zero unless a field byte is shown
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != nals_pkg::OUT_BYTE |-> rsp_tdata[7:0] == 8'd0)
      else $error("stray byte on non-byte result");

   // count only on end of list
   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != nals_pkg::OUT_LIST_END |-> rsp_tdata[25:10] == 16'd0)
      else $error("field count outside end of list");

   // error results carry a code, bytes and field ends carry none
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ((rsp_tuser == nals_pkg::OUT_ERROR) == (rsp_tdata[9:8] != nals_pkg::ERR_NONE)) ||
         (rsp_tuser == nals_pkg::OUT_LIST_END))
      else $error("error code does not match result kind");

endmodule

bind nest_aware_list_splitter nals_checker u_nals_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[bench/nals_checker.sv]
`timescale 1ns / 100ps

module nals_scoreboard #(
   parameter int NEST_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tuser,   // kind
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // out_byte, error_code, field_count, zero pad
   input  logic [1:0]  rsp_tuser,   // out_kind
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,    // separator
   output int          outstanding,
   output int          fail_count,
   output int          results_checked
);
   import nals_pkg::*;

   // one result of the splitter as it should appear on the rsp side
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [1:0]  code;
      logic [15:0] count;
   } token_type;

   token_type   awaited_tokens[$];
   token_type   want;
   int          mismatches = 0;
   int          checked = 0;

   // shadow of the splitter state
   logic [7:0]  separator = SEP_RESET;
   logic [1:0]  nest_kinds [NEST_DEPTH];
   int          open_depth;
   logic        in_quotes;
   logic        escape_armed;
   logic        text_dropped;
   logic [15:0] field_tally;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] awaited);
      if (mismatches < 40)
         $display("%0t: %s mismatch, got %0h, awaited %0h", $time, what, got, awaited);
      mismatches++;
   endtask

   task automatic clear_text();
      open_depth   = 0;
      in_quotes    = 1'b0;
      escape_armed = 1'b0;
      text_dropped = 1'b0;
      field_tally  = '0;
   endtask

   task automatic await_token(input logic [1:0] kind, input logic [7:0] data,
                              input logic [1:0] code, input logic [15:0] count);
      token_type t;
      t.kind  = kind;
      t.data  = data;
      t.code  = code;
      t.count = count;
      awaited_tokens.push_back(t);
   endtask

   function automatic logic [1:0] bracket_kind(input logic [7:0] c);
      if (c == CH_LSQ || c == CH_RSQ) return BK_SQUARE;
      if (c == CH_LPAR || c == CH_RPAR) return BK_PAREN;
      return BK_CURLY;
   endfunction

   // advance the shadow state by one input transaction
   task automatic split_char(input logic kind, input logic [7:0] c);
      logic [1:0]  code;
      logic [15:0] tally;
      if (kind == IN_EOT) begin
         code  = ERR_NONE;
         tally = '0;
         if (!text_dropped) begin
            tally = (field_tally == COUNT_MAX) ? COUNT_MAX : field_tally + 16'd1;
            if (escape_armed) code = ERR_ESCAPE;
         end
         clear_text();
         await_token(OUT_LIST_END, 8'd0, code, tally);
      end else if (!text_dropped) begin
         if (escape_armed) begin
            // escaped character
            escape_armed = 1'b0;
            case (c)
               CH_N:      await_token(OUT_BYTE, CH_LF, ERR_NONE, '0);
               CH_T:      await_token(OUT_BYTE, CH_TAB, ERR_NONE, '0);
               CH_BSLASH: await_token(OUT_BYTE, CH_BSLASH, ERR_NONE, '0);
               CH_QUOTE:  await_token(OUT_BYTE, CH_QUOTE, ERR_NONE, '0);
               default:   await_token(OUT_ERROR, 8'd0, ERR_ESCAPE, '0);
            endcase
         end else if (c == separator && open_depth == 0) begin
            if (field_tally != COUNT_MAX) field_tally++;
            await_token(OUT_FIELD_END, 8'd0, ERR_NONE, '0);
         end else if (c == CH_BSLASH) begin
            escape_armed = 1'b1;
         end else if (c == CH_QUOTE) begin
            in_quotes = !in_quotes;
         end else if (c == CH_LSQ || c == CH_LPAR || c == CH_LCUR) begin
            // push, or give up the text on a full stack
            if (open_depth >= NEST_DEPTH) begin
               text_dropped = 1'b1;
               await_token(OUT_ERROR, 8'd0, ERR_OVERFLOW, '0);
            end else begin
               nest_kinds[open_depth] = bracket_kind(c);
               open_depth++;
               await_token(OUT_BYTE, c, ERR_NONE, '0);
            end
         end else if (c == CH_RSQ || c == CH_RPAR || c == CH_RCUR) begin
            // pop on a matching close, else give up the text
            if (open_depth == 0 || nest_kinds[open_depth - 1] != bracket_kind(c)) begin
               text_dropped = 1'b1;
               await_token(OUT_ERROR, 8'd0, ERR_CLOSE, '0);
            end else begin
               open_depth--;
               await_token(OUT_BYTE, c, ERR_NONE, '0);
            end
         end else if (in_quotes || (c != CH_SPACE && c != CH_TAB && c != CH_LF)) begin
            await_token(OUT_BYTE, c, ERR_NONE, '0);
         end
      end
   endtask

   // watch the three channels at every edge
   always @(posedge clock) begin
      if (reset) begin
         separator = SEP_RESET;
         clear_text();
         awaited_tokens.delete();
      end else begin
         if (csr_valid && csr_ready) separator = csr_data;
         if (req_tvalid && req_tready) split_char(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (awaited_tokens.size() == 0) begin
               report_mismatch("unawaited result", {14'd0, rsp_tuser}, 16'd0);
            end else begin
               want = awaited_tokens.pop_front();
               if (rsp_tuser != want.kind)
                  report_mismatch("out_kind", {14'd0, rsp_tuser}, {14'd0, want.kind});
               if (rsp_tdata[7:0] != want.data)
                  report_mismatch("out_byte", {8'd0, rsp_tdata[7:0]}, {8'd0, want.data});
               if (rsp_tdata[9:8] != want.code)
                  report_mismatch("error_code", {14'd0, rsp_tdata[9:8]}, {14'd0, want.code});
               if (rsp_tdata[25:10] != want.count)
                  report_mismatch("field_count", rsp_tdata[25:10], want.count);
               if (rsp_tdata[31:26] != 6'd0)
                  report_mismatch("tdata pad", {10'd0, rsp_tdata[31:26]}, 16'd0);
            end
         end
      end
      outstanding     <= awaited_tokens.size();
      fail_count      <= mismatches;
      results_checked <= checked;
   end

endmodule

[bench/tb_nest_aware_list_splitter.sv]
`timescale 1ns / 100ps

module tb_nest_aware_list_splitter;
   import nals_pkg::*;

   localparam int NEST_DEPTH  = 16;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 210;

   // flow-control mixes
   localparam int MODE_FREE       = 0;
   localparam int MODE_SEND_IDLE  = 1;
   localparam int MODE_RECV_STALL = 2;
   localparam int MODE_BOTH       = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tuser = IN_CHAR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = SEP_RESET;

   int          outstanding;
   int          fail_count;
   int          results_checked;

   int          stall_pct = 0;
   logic        hold_req = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;
   int          cycle_count = 0;
   int          send_idle = 0;
   logic [7:0]  sep_now = SEP_RESET;
   logic [7:0]  open_closers[$];
   int          texts_sent = 0;
   int          chars_sent = 0;

   always #10 clock = ~clock;

   nest_aware_list_splitter #(.NEST_DEPTH(NEST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   nals_scoreboard #(.NEST_DEPTH(NEST_DEPTH)) split_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .outstanding     (outstanding),
      .fail_count      (fail_count),
      .results_checked (results_checked)
   );

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen  <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL nest_aware_list_splitter");
         $finish;
      end
   end

   // one input transaction, with random idle cycles ahead of it
   task automatic send_item(input logic kind, input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
      if (kind == IN_EOT) texts_sent++;
   endtask

   task automatic send_string(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_item(IN_CHAR, s[i]);
   endtask

   // stop sending until every awaited result is in, then settle
   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_separator(input logic [7:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sep_now = v;
   endtask

   task automatic set_mode(input int mode);
      case (mode)
         MODE_FREE:       begin send_idle = 0;  stall_pct <= 0;  end
         MODE_SEND_IDLE:  begin send_idle = 69; stall_pct <= 0;  end
         MODE_RECV_STALL: begin send_idle = 0;  stall_pct <= 69; end
         default:         begin send_idle = 30; stall_pct <= 30; end
      endcase
   endtask

   task automatic open_bracket();
      case ($urandom_range(2))
         0: begin
            send_item(IN_CHAR, CH_LSQ);
            open_closers.push_back(CH_RSQ);
         end
         1: begin
            send_item(IN_CHAR, CH_LPAR);
            open_closers.push_back(CH_RPAR);
         end
         default: begin
            send_item(IN_CHAR, CH_LCUR);
            open_closers.push_back(CH_RCUR);
         end
      endcase
   endtask

   // one text: mostly well-formed fields with random content, some raw noise
   task automatic send_random_text();
      int         ntok;
      int         pick;
      logic [7:0] b;
      ntok = $urandom_range(1, 14);
      if ($urandom_range(99) < 10) begin
         repeat (ntok) send_item(IN_CHAR, 8'($urandom_range(255)));
      end else begin
         // sometimes nest right up to, or past, the stack limit
         if ($urandom_range(99) < 6)
            repeat (NEST_DEPTH - 1 + $urandom_range(2)) open_bracket();
         repeat (ntok) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
               send_item(IN_CHAR, 8'($urandom_range(8'h61, 8'h7a)));
            end else if (pick < 38) begin
               send_item(IN_CHAR, 8'($urandom_range(255)));
            end else if (pick < 48) begin
               case ($urandom_range(3))
                  0:       b = CH_SPACE;
                  1:       b = CH_TAB;
                  2:       b = CH_LF;
                  default: b = 8'h0d;
               endcase
               send_item(IN_CHAR, b);
            end else if (pick < 60) begin
               send_item(IN_CHAR, sep_now);
            end else if (pick < 70) begin
               send_item(IN_CHAR, CH_BSLASH);
               case ($urandom_range(4))
                  0:       b = CH_N;
                  1:       b = CH_T;
                  2:       b = CH_BSLASH;
                  3:       b = CH_QUOTE;
                  default: b = 8'($urandom_range(255));
               endcase
               send_item(IN_CHAR, b);
            end else if (pick < 76) begin
               send_item(IN_CHAR, CH_QUOTE);
            end else if (pick < 87) begin
               open_bracket();
            end else if (pick < 95 && open_closers.size() != 0) begin
               send_item(IN_CHAR, open_closers.pop_back());
            end else begin
               // close that is likely wrong or unmatched
               case ($urandom_range(2))
                  0:       b = CH_RSQ;
                  1:       b = CH_RPAR;
                  default: b = CH_RCUR;
               endcase
               send_item(IN_CHAR, b);
            end
         end
         if ($urandom_range(9) != 0)
            while (open_closers.size() != 0) send_item(IN_CHAR, open_closers.pop_back());
         if ($urandom_range(99) < 4) send_item(IN_CHAR, CH_BSLASH);
      end
      open_closers.delete();
      send_item(IN_EOT, 8'($urandom_range(255)));
   endtask

   // stimulus
   initial begin
      logic [7:0] phase_seps [8];
      int         phase;
      int         start;
      phase_seps = '{SEP_RESET, 8'h00, 8'hff, CH_QUOTE, CH_BSLASH, CH_LSQ, 8'h00, 8'd59};
      phase_seps[6] = 8'($urandom_range(255));
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // quoted blank, escapes, separator inside brackets
      send_string("\"a b\",\\t\\q[x,()]");
      send_item(IN_EOT, 8'h00);
      // backslash and quote escapes, wrong close, dropped tail
      send_string("\\n\\\\\\\"}z");
      send_item(IN_EOT, 8'hff);
      // extreme bytes and a trailing backslash
      send_item(IN_CHAR, 8'h00);
      send_item(IN_CHAR, 8'hff);
      send_item(IN_CHAR, CH_BSLASH);
      send_item(IN_EOT, 8'h00);

      for (phase = 0; phase < 8; phase++) begin
         if (phase != 0) begin
            drain(4);
            write_separator(phase_seps[phase]);
         end
         set_mode(phase % 4);
         if (phase % 4 == MODE_FREE) hold_req <= ~hold_req;
         start = chars_sent;
         while (chars_sent - start < PHASE_ITEMS / 2) send_random_text();
         drain(0);
         while (chars_sent - start < PHASE_ITEMS) send_random_text();
      end
      drain(8);

      $display("covered %0d texts, %0d input transactions, %0d results checked",
               texts_sent, chars_sent, results_checked);
      $display("eight separator settings, four flow-control mixes, long receiver holds");
      if (fail_count == 0)
         $display("PASS nest_aware_list_splitter");
      else
         $display("FAIL nest_aware_list_splitter");
      $finish;
   end

endmodule
